[rtl/qrm_pkg.sv]
// ----------------------------------------------------------------------------
// qrm_pkg: shared types for the quaternion to rotation matrix block
// Input quaternion and output matrix transaction types, element limits.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int ELEM_MAX = 32767;
  localparam int ELEM_MIN = -32768;

  typedef struct packed {
    logic signed [ELEM_W-1:0] quat_x;
    logic signed [ELEM_W-1:0] quat_y;
    logic signed [ELEM_W-1:0] quat_z;
    logic signed [ELEM_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] rot_r0c0;
    logic signed [ELEM_W-1:0] rot_r0c1;
    logic signed [ELEM_W-1:0] rot_r0c2;
    logic signed [ELEM_W-1:0] rot_r1c0;
    logic signed [ELEM_W-1:0] rot_r1c1;
    logic signed [ELEM_W-1:0] rot_r1c2;
    logic signed [ELEM_W-1:0] rot_r2c0;
    logic signed [ELEM_W-1:0] rot_r2c1;
    logic signed [ELEM_W-1:0] rot_r2c2;
    logic                     saturated;
  } rot_t;

endpackage

[rtl/qrm_finish.sv]
// ----------------------------------------------------------------------------
// qrm_finish: matrix element rounding and saturation
// Scales a product sum by two, subtracts it from one on the diagonal, rounds
// to nearest (ties up) at FRAC_BITS and clips to 16 bits. Two register stages.
// ----------------------------------------------------------------------------
module qrm_finish
  import qrm_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  parameter bit DIAG      = 1'b0
) (
  input  logic                     clk,
  input  logic signed [SUM_W-1:0]  sum_in,
  output logic signed [ELEM_W-1:0] elem,
  output logic                     sat
);

  localparam int EW = (2 * FRAC_BITS + 3 > SUM_W + 3) ? 2 * FRAC_BITS + 3 : SUM_W + 3;
  localparam int RW = EW - FRAC_BITS;

  localparam logic signed [EW-1:0] ONE   = {{(EW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);
  localparam logic signed [EW-1:0] ROUND = {{(EW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [RW-1:0] HI    = RW'(ELEM_MAX);
  localparam logic signed [RW-1:0] LO    = RW'(ELEM_MIN);

  logic signed [EW-1:0] twice;
  logic signed [EW-1:0] exact;
  logic signed [EW-1:0] rounded;
  logic signed [RW-1:0] r;
  logic signed [RW-1:0] r_next;

  always_comb begin
    twice   = {{(EW-SUM_W){sum_in[SUM_W-1]}}, sum_in} <<< 1;
    exact   = DIAG ? (ONE - twice) : twice;
    rounded = exact + ROUND;
    // floor at FRAC_BITS: keep the upper bits, sign included
    r_next  = rounded[EW-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    r <= r_next;
    if (r > HI) begin
      elem <= ELEM_W'(ELEM_MAX);
      sat  <= 1'b1;
    end else if (r < LO) begin
      elem <= ELEM_W'(ELEM_MIN);
      sat  <= 1'b1;
    end else begin
      elem <= r[ELEM_W-1:0];
      sat  <= 1'b0;
    end
  end

endmodule

[rtl/quaternion_to_rotation_matrix.sv]
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix: fixed-point quaternion to 3x3 rotation matrix
// Five-stage pipeline: capture, nine products, pair sums, round, saturate.
// ----------------------------------------------------------------------------
// Usage:
//   Drive quat (x, y, z, w, signed with FRAC_BITS fraction bits) and raise
//   start. A transaction is taken at each rising edge with start high and
//   busy low. Busy is high only while rst is held and for the cycle after.
//   The nine elements and the saturated flag appear on rot with done high for
//   exactly one cycle. Throughput is one transaction per cycle outside reset;
//   the register stages are input capture, 16x16 multipliers, product sums,
//   the wide round add, and the saturation compare.
//   The receiver cannot stall; rot is valid only while done is high.
//   Reset drops every transaction in flight; no done follows.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix
  import qrm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  quat_t quat,
  output logic  busy,
  output logic  done,
  output rot_t  rot
);

  logic        v1, v2, v3, v4;
  quat_t       q1;
  logic signed [PROD_W-1:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  logic signed [SUM_W-1:0]  sums [9];
  logic signed [ELEM_W-1:0] elems [9];
  logic [8:0]  sats;
  logic        accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // payload path, no reset
  always_ff @(posedge clk) begin
    q1 <= quat;

    p_xx <= q1.quat_x * q1.quat_x;
    p_yy <= q1.quat_y * q1.quat_y;
    p_zz <= q1.quat_z * q1.quat_z;
    p_xy <= q1.quat_x * q1.quat_y;
    p_xz <= q1.quat_x * q1.quat_z;
    p_yz <= q1.quat_y * q1.quat_z;
    p_wx <= q1.quat_w * q1.quat_x;
    p_wy <= q1.quat_w * q1.quat_y;
    p_wz <= q1.quat_w * q1.quat_z;

    sums[0] <= SUM_W'(p_yy) + SUM_W'(p_zz);
    sums[1] <= SUM_W'(p_xy) + SUM_W'(p_wz);
    sums[2] <= SUM_W'(p_xz) - SUM_W'(p_wy);
    sums[3] <= SUM_W'(p_xy) - SUM_W'(p_wz);
    sums[4] <= SUM_W'(p_xx) + SUM_W'(p_zz);
    sums[5] <= SUM_W'(p_yz) + SUM_W'(p_wx);
    sums[6] <= SUM_W'(p_xz) + SUM_W'(p_wy);
    sums[7] <= SUM_W'(p_yz) - SUM_W'(p_wx);
    sums[8] <= SUM_W'(p_xx) + SUM_W'(p_yy);
  end

  for (genvar i = 0; i < 9; i++) begin : g_elem
    qrm_finish #(
      .FRAC_BITS (FRAC_BITS),
      .DIAG      ((i == 0) || (i == 4) || (i == 8))
    ) u_finish (
      .clk    (clk),
      .sum_in (sums[i]),
      .elem   (elems[i]),
      .sat    (sats[i])
    );
  end

  always_comb begin
    rot.rot_r0c0  = elems[0];
    rot.rot_r0c1  = elems[1];
    rot.rot_r0c2  = elems[2];
    rot.rot_r1c0  = elems[3];
    rot.rot_r1c1  = elems[4];
    rot.rot_r1c2  = elems[5];
    rot.rot_r2c0  = elems[6];
    rot.rot_r2c1  = elems[7];
    rot.rot_r2c2  = elems[8];
    rot.saturated = |sats;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted transaction did not complete after five cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("done without a matching accepted transaction");

  a_busy_clear: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy)
    else $error("busy raised outside reset");

endmodule
